// ----- design/tria3d_pkg.sv -----
// ---------------------------------------------------------------------------
// tria3d_pkg
// Shared types and constants for the 3D triangle area pipeline.
// ---------------------------------------------------------------------------
package tria3d_pkg;

  // width of the area result field
  localparam int AREA_BITS = 41;

  // per-stage handshake into a pipeline section: global advance and request valid
  typedef struct packed {
    logic en;
    logic vld;
  } stage_ctl_t;

endpackage

// ----- design/triangle_area_3d_core.sv -----
// ---------------------------------------------------------------------------
// triangle_area_3d_core
// Area of a 3D triangle from its vertices, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel, nine signed COORD_BITS coordinates (A, B, C).
//   out_* : valid/ready channel, area in unsigned fixed point with FRAC_BITS
//           fraction bits, floored, saturating at all ones.
//   Throughput: one request per cycle when out_ready stays high.
//   Stages: 3 cross-product stages, 4 sum-of-squares stages, one stage per
//   root bit (2*COORD_BITS + FRAC_BITS + 4) and the output register. The
//   bit-per-stage square root sets the depth.
//   Stall: the whole pipeline holds while out_valid is high and out_ready is
//   low; an input skid register takes one more request during the stall, so
//   in_ready drops only once it is occupied.
//   Reset: synchronous, active low; clears all valid bits, so out_valid is low
//   and in_ready is high in the first cycle after reset.
// ---------------------------------------------------------------------------
module triangle_area_3d_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          in_ax,
  input  logic signed [COORD_BITS-1:0]          in_ay,
  input  logic signed [COORD_BITS-1:0]          in_az,
  input  logic signed [COORD_BITS-1:0]          in_bx,
  input  logic signed [COORD_BITS-1:0]          in_by_coord,
  input  logic signed [COORD_BITS-1:0]          in_bz,
  input  logic signed [COORD_BITS-1:0]          in_cx,
  input  logic signed [COORD_BITS-1:0]          in_cy,
  input  logic signed [COORD_BITS-1:0]          in_cz,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [tria3d_pkg::AREA_BITS-1:0]      out_area
);

  localparam int CW   = COORD_BITS;
  localparam int NW   = 2 * (CW + 1) + 1;
  localparam int DETW = 2 * NW + 2;

  logic [9*CW-1:0] in_coords;
  logic [9*CW-1:0] skid_r;
  logic            skid_vld_r;
  logic            en;

  tria3d_pkg::stage_ctl_t cross_ctl, sqsum_ctl, sqrt_ctl;

  logic                 cross_vld, sqsum_vld;
  logic signed [NW-1:0] nx, ny, nz;
  logic [DETW-1:0]      det;

  assign in_coords = {in_cz, in_cy, in_cx, in_bz, in_by_coord, in_bx, in_az, in_ay, in_ax};

  assign en       = !out_valid || out_ready;
  assign in_ready = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (en) begin
      skid_vld_r <= 1'b0;
    end else if (in_valid && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  // capture only while stalled and empty
  always_ff @(posedge clk) begin
    if (!en && !skid_vld_r) begin
      skid_r <= in_coords;
    end
  end

  assign cross_ctl.en  = en;
  assign cross_ctl.vld = skid_vld_r || in_valid;
  assign sqsum_ctl.en  = en;
  assign sqsum_ctl.vld = cross_vld;
  assign sqrt_ctl.en   = en;
  assign sqrt_ctl.vld  = sqsum_vld;

  tria3d_cross #(
    .CW (CW),
    .NW (NW)
  ) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cross_ctl),
    .coords  (skid_vld_r ? skid_r : in_coords),
    .out_vld (cross_vld),
    .nx      (nx),
    .ny      (ny),
    .nz      (nz)
  );

  tria3d_sqsum #(
    .NW   (NW),
    .DETW (DETW)
  ) u_sqsum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sqsum_ctl),
    .nx      (nx),
    .ny      (ny),
    .nz      (nz),
    .out_vld (sqsum_vld),
    .det     (det)
  );

  tria3d_sqrt #(
    .DETW (DETW),
    .FB   (FRAC_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sqrt_ctl),
    .det      (det),
    .out_vld  (out_valid),
    .out_area (out_area)
  );

`ifndef SYNTH
  a_skid_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !en) |=> skid_vld_r)
    else $error("core: request taken during stall was not parked in skid");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !en) |=> (skid_vld_r && $stable(skid_r)))
    else $error("core: parked request lost or changed during stall");
`endif

endmodule

// ----- design/tria3d_cross.sv -----
// ---------------------------------------------------------------------------
// tria3d_cross
// Edge vectors from the first vertex and their cross product, three stages.
// ---------------------------------------------------------------------------
module tria3d_cross #(
  parameter int CW = 16,
  parameter int NW = 2 * (CW + 1) + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tria3d_pkg::stage_ctl_t ctl,
  input  logic [9*CW-1:0]        coords,
  output logic                   out_vld,
  output logic signed [NW-1:0]   nx,
  output logic signed [NW-1:0]   ny,
  output logic signed [NW-1:0]   nz
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic [CW-1:0] ax, ay, az, bx, by_c, bz, cx, cy, cz;

  assign ax   = coords[0*CW +: CW];
  assign ay   = coords[1*CW +: CW];
  assign az   = coords[2*CW +: CW];
  assign bx   = coords[3*CW +: CW];
  assign by_c = coords[4*CW +: CW];
  assign bz   = coords[5*CW +: CW];
  assign cx   = coords[6*CW +: CW];
  assign cy   = coords[7*CW +: CW];
  assign cz   = coords[8*CW +: CW];

  logic signed [DW-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [DW-1:0] ux_nxt, uy_nxt, uz_nxt, vx_nxt, vy_nxt, vz_nxt;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic                 v1_r, v2_r, v3_r;

  always_comb begin
    ux_nxt = {bx[CW-1], bx} - {ax[CW-1], ax};
    uy_nxt = {by_c[CW-1], by_c} - {ay[CW-1], ay};
    uz_nxt = {bz[CW-1], bz} - {az[CW-1], az};
    vx_nxt = {cx[CW-1], cx} - {ax[CW-1], ax};
    vy_nxt = {cy[CW-1], cy} - {ay[CW-1], ay};
    vz_nxt = {cz[CW-1], cz} - {az[CW-1], az};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctl.en) begin
      v1_r <= ctl.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      uz_r <= uz_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
      vz_r <= vz_nxt;
      p0_r <= ux_r * vz_r;  // six partial products, two per cross-product component
      p1_r <= uz_r * vx_r;
      p2_r <= uy_r * vz_r;
      p3_r <= uz_r * vy_r;
      p4_r <= ux_r * vy_r;
      p5_r <= uy_r * vx_r;
      nx_r <= {p2_r[PW-1], p2_r} - {p3_r[PW-1], p3_r};
      ny_r <= {p1_r[PW-1], p1_r} - {p0_r[PW-1], p0_r};
      nz_r <= {p4_r[PW-1], p4_r} - {p5_r[PW-1], p5_r};
    end
  end

  assign out_vld = v3_r;
  assign nx      = nx_r;
  assign ny      = ny_r;
  assign nz      = nz_r;

endmodule

// ----- design/tria3d_sqsum.sv -----
// ---------------------------------------------------------------------------
// tria3d_sqsum
// Exact sum of squares of the cross product, squares split into partials.
// ---------------------------------------------------------------------------
module tria3d_sqsum #(
  parameter int NW   = 35,
  parameter int DETW = 2 * NW + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tria3d_pkg::stage_ctl_t ctl,
  input  logic signed [NW-1:0]   nx,
  input  logic signed [NW-1:0]   ny,
  input  logic signed [NW-1:0]   nz,
  output logic                   out_vld,
  output logic [DETW-1:0]        det
);

  localparam int MW = NW;
  localparam int LW = (MW + 1) / 2;
  localparam int HW = MW - LW;
  localparam int SW = 2 * MW;

  logic [MW-1:0]      mag_r [3];
  logic [2*LW-1:0]    ll_r  [3];
  logic [LW+HW-1:0]   lh_r  [3];
  logic [2*HW-1:0]    hh_r  [3];
  logic [SW-1:0]      sq_r  [3];
  logic [DETW-1:0]    det_r;
  logic signed [NW-1:0] n_in [3];
  logic [MW-1:0]      mag_nxt [3];
  logic [SW-1:0]      sq_nxt  [3];
  logic [3:0]         vld_r;

  assign n_in[0] = nx;
  assign n_in[1] = ny;
  assign n_in[2] = nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = n_in[i][NW-1] ? (~n_in[i] + MW'(1)) : n_in[i];
      sq_nxt[i]  = (SW'(hh_r[i]) << (2 * LW)) + (SW'(lh_r[i]) << (LW + 1)) + SW'(ll_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag_nxt[i];
        ll_r[i]  <= mag_r[i][LW-1:0] * mag_r[i][LW-1:0];
        lh_r[i]  <= mag_r[i][LW-1:0] * mag_r[i][MW-1:LW];
        hh_r[i]  <= mag_r[i][MW-1:LW] * mag_r[i][MW-1:LW];
        sq_r[i]  <= sq_nxt[i];
      end
      det_r <= DETW'(sq_r[0]) + DETW'(sq_r[1]) + DETW'(sq_r[2]);
    end
  end

  assign out_vld = vld_r[3];
  assign det     = det_r;

endmodule

// ----- design/tria3d_sqrt.sv -----
// ---------------------------------------------------------------------------
// tria3d_sqrt
// Restoring square root, one result bit per stage, then halve and saturate.
// ---------------------------------------------------------------------------
module tria3d_sqrt #(
  parameter int DETW = 72,
  parameter int FB   = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tria3d_pkg::stage_ctl_t             ctl,
  input  logic [DETW-1:0]                    det,
  output logic                               out_vld,
  output logic [tria3d_pkg::AREA_BITS-1:0]   out_area
);

  localparam int AB  = tria3d_pkg::AREA_BITS;
  localparam int XW  = DETW + 2 * FB;
  localparam int R   = XW / 2;
  localparam int RMW = R + 3;
  localparam int EW  = (R > AB + 1) ? R : AB + 2;

  logic [RMW-1:0] rem_r  [R];
  logic [R-1:0]   root_r [R];
  logic [XW-1:0]  x_r    [R];
  logic           vld_r  [R];
  logic [XW-1:0]  det_x;

  assign det_x = XW'(det) << (2 * FB);

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic [RMW-1:0] rem_in, rem_sh, trial, rem_nxt;
    logic [R-1:0]   root_in, root_nxt;
    logic [XW-1:0]  x_in;
    logic           vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = det_x;
      assign vld_in  = ctl.vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[RMW-3:0], x_in[XW-1:XW-2]};
      trial  = (RMW'(root_in) << 2) | RMW'(1);
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[R-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[R-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        x_r[k]    <= x_in << 2;
      end
    end
  end

  logic [EW-1:0] root_e;
  logic          sat;
  logic [AB-1:0] area_nxt;
  logic [AB-1:0] out_area_r;
  logic          out_vld_r;

  always_comb begin
    root_e   = EW'(root_r[R-1]);
    sat      = |root_e[EW-1:AB+1];
    area_nxt = sat ? {AB{1'b1}} : root_e[AB:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.en) begin
      out_vld_r <= vld_r[R-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      out_area_r <= area_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_area = out_area_r;

`ifndef SYNTH
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.en && vld_r[R-1]) |=> out_vld_r)
    else $error("sqrt: last stage request did not reach output register");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.en |=> ($stable(out_area_r) && $stable(out_vld_r)))
    else $error("sqrt: output register changed during stall");
`endif

endmodule

// ----- bench/tb_triangle_area_3d_core.sv -----
// ---------------------------------------------------------------------------
// tb_triangle_area_3d_core
// Self-checking bench for the 3D triangle area pipeline. A directed table
// covers extreme, degenerate and exactly known triangles. A random stream
// follows, mixing full-range, small, degenerate and corner coordinates.
// Each request is scored against its typed area or an exact integer area
// predictor; random idle gaps on the input side, random stalls on output.
// ---------------------------------------------------------------------------
module tb_triangle_area_3d_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS     = 16;
  localparam int FRAC_BITS      = 8;
  localparam int AREA_BITS      = tria3d_pkg::AREA_BITS;
  localparam int N_RANDOM       = 840;
  localparam int IDLE_LIMIT     = 2000;
  localparam int TAIL_CYCLES    = 2 * COORD_BITS + FRAC_BITS + 20;
  localparam int N_TABLE        = 14;

  typedef logic [AREA_BITS-1:0] area_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax, ay, az;
    logic signed [COORD_BITS-1:0] bx, by, bz;
    logic signed [COORD_BITS-1:0] cx, cy, cz;
  } tri_t;

  // directed row: vertices as ints, plus a typed area where it is obvious
  typedef struct {
    int     ax, ay, az, bx, by, bz, cx, cy, cz;
    bit     known;
    longint area;
  } tri_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [COORD_BITS-1:0] in_bx = '0, in_by_coord = '0, in_bz = '0;
  logic signed [COORD_BITS-1:0] in_cx = '0, in_cy = '0, in_cz = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  area_t                        out_area;

  area_t area_q[$];
  int    err_cnt = 0;
  int    idle_cycles = 0;
  int    stall_left = 0;
  bit    calm = 1'b0;

  tri_row_t tri_table [N_TABLE] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1, 0},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 0},
    '{-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767, 1, 0},
    '{5, -7, 9, 5, -7, 9, 100, 200, -300, 1, 0},
    '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 128},
    '{0, 0, 0, 1, 0, 0, 0, 0, 1, 1, 128},
    '{0, 0, 0, 2, 0, 0, 0, 2, 0, 1, 512},
    '{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0, 1, 64'd549739036800},
    '{0, 0, 0, 1, 0, 0, 1, 1, 1, 0, 0},
    '{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767, 0, 0},
    '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768, 0, 0},
    '{-1, -1, -1, 1, 1, 1, -1, 1, -1, 0, 0},
    '{12345, -23456, 31000, -30000, 29999, -1, 7, -32768, 32767, 0, 0}
  };

  triangle_area_3d_core #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ax      (in_ax),
    .in_ay      (in_ay),
    .in_az      (in_az),
    .in_bx      (in_bx),
    .in_by_coord(in_by_coord),
    .in_bz      (in_bz),
    .in_cx      (in_cx),
    .in_cy      (in_cy),
    .in_cz      (in_cz),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_area   (out_area)
  );

  always #5 clk = ~clk;

  // exact area: floor(sqrt(|AB x AC|^2 * 4^FRAC_BITS)) / 2, saturating
  function automatic area_t tri_area(tri_t t);
    longint      ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0] mx, my, mz, rad, rem, root, trial;
    ux = longint'(t.bx) - longint'(t.ax);
    uy = longint'(t.by) - longint'(t.ay);
    uz = longint'(t.bz) - longint'(t.az);
    vx = longint'(t.cx) - longint'(t.ax);
    vy = longint'(t.cy) - longint'(t.ay);
    vz = longint'(t.cz) - longint'(t.az);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    mx = (nx < 0) ? -nx : nx;
    my = (ny < 0) ? -ny : ny;
    mz = (nz < 0) ? -nz : nz;
    rad = (mx * mx + my * my + mz * mz) << (2 * FRAC_BITS);
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    if (root >= (128'd1 << (AREA_BITS + 1)))
      return '1;
    return area_t'(root >> 1);
  endfunction

  function automatic tri_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                  int cx, int cy, int cz);
    tri_t t;
    t.ax = COORD_BITS'(ax); t.ay = COORD_BITS'(ay); t.az = COORD_BITS'(az);
    t.bx = COORD_BITS'(bx); t.by = COORD_BITS'(by); t.bz = COORD_BITS'(bz);
    t.cx = COORD_BITS'(cx); t.cy = COORD_BITS'(cy); t.cz = COORD_BITS'(cz);
    return t;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60)
      return 0;
    if (r < 93)
      return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int near(int base, int span);
    return base + int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic tri_t random_tri();
    int a [3];
    int d [3];
    int k;
    tri_t t;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        t = tri_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      end
      5, 6: begin
        // small triangle somewhere in the grid
        for (int i = 0; i < 3; i++)
          a[i] = near(0, 32000);
        t = mk_tri(a[0], a[1], a[2],
                   near(a[0], 8), near(a[1], 8), near(a[2], 8),
                   near(a[0], 8), near(a[1], 8), near(a[2], 8));
      end
      7: begin
        // collinear or coincident vertices
        for (int i = 0; i < 3; i++) begin
          a[i] = near(0, 30000);
          d[i] = near(0, 100);
        end
        k = near(0, 3);
        t = mk_tri(a[0], a[1], a[2], a[0] + d[0], a[1] + d[1], a[2] + d[2],
                   a[0] + k * d[0], a[1] + k * d[1], a[2] + k * d[2]);
      end
      default: begin
        t = mk_tri(corner_coord(), corner_coord(), corner_coord(),
                   corner_coord(), corner_coord(), corner_coord(),
                   corner_coord(), corner_coord(), corner_coord());
      end
    endcase
    return t;
  endfunction

  task automatic report(string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic send_tri(tri_t t, bit known, area_t typed_area);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ax <= t.ax; in_ay <= t.ay; in_az <= t.az;
    in_bx <= t.bx; in_by_coord <= t.by; in_bz <= t.bz;
    in_cx <= t.cx; in_cy <= t.cy; in_cz <= t.cz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    area_q.push_back(known ? typed_area : tri_area(t));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (area_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, then score against the oldest expectation
  always @(posedge clk) begin
    area_t want;
    if (rst_n && out_valid && out_ready) begin
      if (area_q.size() == 0) begin
        report($sformatf("unexpected area %0d", out_area));
      end else begin
        want = area_q.pop_front();
        if (out_area !== want)
          report($sformatf("area got %0d want %0d", out_area, want));
      end
    end
    if (stall_left == 0 && $urandom_range(99) < 20)
      stall_left = pick_gap();
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_triangle_area_3d_core failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    tri_row_t row;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tri_table[i]) begin
      row = tri_table[i];
      send_tri(mk_tri(row.ax, row.ay, row.az, row.bx, row.by, row.bz,
                      row.cx, row.cy, row.cz), row.known, area_t'(row.area));
    end
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      // windows with no idling on either side
      calm = (n >= 200 && n < 300) || (n >= 600 && n < 660);
      if (n == 420)
        drain();
      send_tri(random_tri(), 1'b0, '0);
    end
    calm = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (area_q.size() != 0)
      report($sformatf("%0d requests never answered", area_q.size()));
    if (err_cnt == 0) begin
      $display("tb_triangle_area_3d_core passed");
    end else begin
      $display("tb_triangle_area_3d_core failed");
    end
    $finish;
  end

endmodule
